// File: rtl/tlelru_pkg.sv
// ----------------------------------------------------------------------------
// tlelru_pkg
// Shared types and constants for the two-level exclusive LRU key store.
// ----------------------------------------------------------------------------
package tlelru_pkg;

  localparam int CntW      = 32;
  localparam int KeyInW    = 32;
  localparam int CfgDataW  = 7;
  localparam int UpperCapW = 5;
  localparam int LowerCapW = 7;

  localparam int UpperCapRst = 16;
  localparam int LowerCapRst = 64;

  typedef enum logic [1:0] {
    OUT_UPPER_HIT = 2'd0,
    OUT_LOWER_HIT = 2'd1,
    OUT_MISS      = 2'd2
  } outcome_e;

  typedef enum logic [0:0] {
    REG_UPPER_CAP = 1'b0,
    REG_LOWER_CAP = 1'b1
  } cfg_idx_e;

endpackage

// File: rtl/two_level_exclusive_lru_cache.sv
// ----------------------------------------------------------------------------
// two_level_exclusive_lru_cache
// Two fully associative recency-ordered key stores (upper and lower level)
// with exclusive placement, parallel compare and shift, hit/miss counters.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  config    cfg_we_i, cfg_index_i, cfg_data_i          in  (write only)
//  access    in_valid_i/in_ready_o, access_key_i        in
//  result    out_valid_o/out_ready_i, outcome_o, counts out
//
//  One request per cycle sustained while results are taken; a request is
//  registered into the lookup stage, and its result is registered behind it.
//  The key rows are flip-flop shift lines compared in parallel every cycle.
//  Reset clears fills, counters and handshake state; key rows are not cleared.
//  A stalled result holds; the request behind it waits and in_ready_o drops.
// ----------------------------------------------------------------------------
module two_level_exclusive_lru_cache #(
  parameter int UPPER_DEPTH = 16,
  parameter int LOWER_DEPTH = 64,
  parameter int KEY_BITS    = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  tlelru_pkg::cfg_idx_e                 cfg_index_i,
  input  logic [tlelru_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [tlelru_pkg::KeyInW-1:0]        access_key_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output tlelru_pkg::outcome_e                 outcome_o,
  output logic [tlelru_pkg::CntW-1:0]          upper_hit_count_o,
  output logic [tlelru_pkg::CntW-1:0]          lower_hit_count_o,
  output logic [tlelru_pkg::CntW-1:0]          miss_count_o
);
  import tlelru_pkg::*;

  localparam int UCW = $clog2(UPPER_DEPTH + 1);
  localparam int LCW = $clog2(LOWER_DEPTH + 1);
  localparam int UIW = (UPPER_DEPTH > 1) ? $clog2(UPPER_DEPTH) : 1;
  localparam int UCapRst = (UpperCapRst > UPPER_DEPTH) ? UPPER_DEPTH : UpperCapRst;
  localparam int LCapRst = (LowerCapRst > LOWER_DEPTH) ? LOWER_DEPTH : LowerCapRst;
  localparam logic [CntW-1:0] CntMax = '1;

  logic [KEY_BITS-1:0] ukey_q [UPPER_DEPTH];
  logic [KEY_BITS-1:0] ukey_d [UPPER_DEPTH];
  logic [KEY_BITS-1:0] lkey_q [LOWER_DEPTH];
  logic [KEY_BITS-1:0] lkey_d [LOWER_DEPTH];

  logic [UCW-1:0] u_fill_q, u_fill_d, u_cap_q, u_cap_d;
  logic [LCW-1:0] l_fill_q, l_fill_d, l_cap_q, l_cap_d;
  logic [CntW-1:0] uhits_q, uhits_d, lhits_q, lhits_d, miss_q, miss_d;

  logic                stage_valid_q, stage_valid_d;
  logic [KEY_BITS-1:0] key_q;
  logic                out_valid_q, out_valid_d;
  outcome_e            outcome_q, outcome_d;

  logic                   accept, fire;
  logic [UPPER_DEPTH-1:0] u_match, u_sfx;
  logic [LOWER_DEPTH-1:0] l_match, l_sfx, l_pfx;
  logic                   u_hit, l_hit, u_full;
  logic [UIW-1:0]         u_vidx;
  logic [KEY_BITS-1:0]    victim;
  logic [UpperCapW-1:0]   u_wval;
  logic [LowerCapW-1:0]   l_wval;
  logic [UCW-1:0]         u_wcap;
  logic [LCW-1:0]         l_wcap;

  assign fire        = stage_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !stage_valid_q || fire;
  assign accept      = in_valid_i && in_ready_o;

  assign out_valid_o       = out_valid_q;
  assign outcome_o         = outcome_q;
  assign upper_hit_count_o = uhits_q;
  assign lower_hit_count_o = lhits_q;
  assign miss_count_o      = miss_q;

  // parallel lookup
  always_comb begin
    for (int i = 0; i < UPPER_DEPTH; i++) begin
      u_match[i] = (i < int'(u_fill_q)) && (ukey_q[i] == key_q);
    end
    for (int i = 0; i < LOWER_DEPTH; i++) begin
      l_match[i] = (i < int'(l_fill_q)) && (lkey_q[i] == key_q);
    end
    // sfx[i]: hit at or above i; pfx[i]: hit at or below i
    for (int i = 0; i < UPPER_DEPTH; i++) begin
      u_sfx[i] = |(u_match >> i);
    end
    for (int i = 0; i < LOWER_DEPTH; i++) begin
      l_sfx[i] = |(l_match >> i);
      l_pfx[i] = |(l_match << (LOWER_DEPTH - 1 - i));
    end
  end

  assign u_hit  = |u_match;
  assign l_hit  = |l_match;
  assign u_full = (u_fill_q >= u_cap_q);
  assign u_vidx = UIW'(u_cap_q - UCW'(1));
  assign victim = ukey_q[u_vidx];

  // capacity clamp for config writes
  assign u_wval = cfg_data_i[UpperCapW-1:0];
  assign l_wval = cfg_data_i[LowerCapW-1:0];

  always_comb begin
    if (u_wval == '0) begin
      u_wcap = UCW'(1);
    end else if (int'(u_wval) > UPPER_DEPTH) begin
      u_wcap = UCW'(UPPER_DEPTH);
    end else begin
      u_wcap = UCW'(u_wval);
    end
    if (l_wval == '0) begin
      l_wcap = LCW'(1);
    end else if (int'(l_wval) > LOWER_DEPTH) begin
      l_wcap = LCW'(LOWER_DEPTH);
    end else begin
      l_wcap = LCW'(l_wval);
    end
  end

  // state update
  always_comb begin
    ukey_d    = ukey_q;
    lkey_d    = lkey_q;
    u_fill_d  = u_fill_q;
    l_fill_d  = l_fill_q;
    uhits_d   = uhits_q;
    lhits_d   = lhits_q;
    miss_d    = miss_q;
    outcome_d = outcome_q;
    u_cap_d   = u_cap_q;
    l_cap_d   = l_cap_q;

    if (fire) begin
      priority if (u_hit) begin
        ukey_d[0] = key_q;
        for (int i = 1; i < UPPER_DEPTH; i++) begin
          if (u_sfx[i]) ukey_d[i] = ukey_q[i-1];
        end
        if (uhits_q != CntMax) uhits_d = uhits_q + CntW'(1);
        outcome_d = OUT_UPPER_HIT;
      end else if (l_hit) begin
        ukey_d[0] = key_q;
        for (int i = 1; i < UPPER_DEPTH; i++) begin
          ukey_d[i] = ukey_q[i-1];
        end
        if (u_full) begin
          // upper LRU becomes lower MRU; rows shift down into the slot freed by the promoted key
          lkey_d[0] = victim;
          for (int i = 1; i < LOWER_DEPTH; i++) begin
            if (l_sfx[i]) lkey_d[i] = lkey_q[i-1];
          end
          u_fill_d = u_cap_q;
        end else begin
          for (int i = 0; i < LOWER_DEPTH - 1; i++) begin
            if (l_pfx[i]) lkey_d[i] = lkey_q[i+1];
          end
          l_fill_d = l_fill_q - LCW'(1);
          u_fill_d = u_fill_q + UCW'(1);
        end
        if (lhits_q != CntMax) lhits_d = lhits_q + CntW'(1);
        outcome_d = OUT_LOWER_HIT;
      end else begin
        if (!u_full) begin
          ukey_d[0] = key_q;
          for (int i = 1; i < UPPER_DEPTH; i++) begin
            ukey_d[i] = ukey_q[i-1];
          end
          u_fill_d = u_fill_q + UCW'(1);
        end else begin
          lkey_d[0] = key_q;
          for (int i = 1; i < LOWER_DEPTH; i++) begin
            lkey_d[i] = lkey_q[i-1];
          end
          l_fill_d = (l_fill_q >= l_cap_q) ? l_cap_q : l_fill_q + LCW'(1);
        end
        if (miss_q != CntMax) miss_d = miss_q + CntW'(1);
        outcome_d = OUT_MISS;
      end
    end

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_UPPER_CAP: begin
          u_cap_d = u_wcap;
          if (u_fill_d > u_wcap) u_fill_d = u_wcap;
        end
        REG_LOWER_CAP: begin
          l_cap_d = l_wcap;
          if (l_fill_d > l_wcap) l_fill_d = l_wcap;
        end
        default: begin
          u_cap_d = u_cap_q;
        end
      endcase
    end
  end

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (accept) begin
      stage_valid_d = 1'b1;
    end else if (fire) begin
      stage_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
      u_fill_q      <= '0;
      l_fill_q      <= '0;
      u_cap_q       <= UCW'(UCapRst);
      l_cap_q       <= LCW'(LCapRst);
      uhits_q       <= '0;
      lhits_q       <= '0;
      miss_q        <= '0;
    end else begin
      stage_valid_q <= stage_valid_d;
      out_valid_q   <= out_valid_d;
      u_fill_q      <= u_fill_d;
      l_fill_q      <= l_fill_d;
      u_cap_q       <= u_cap_d;
      l_cap_q       <= l_cap_d;
      uhits_q       <= uhits_d;
      lhits_q       <= lhits_d;
      miss_q        <= miss_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= KEY_BITS'(access_key_i);
    end
    outcome_q <= outcome_d;
    ukey_q    <= ukey_d;
    lkey_q    <= lkey_d;
  end

endmodule

// File: rtl/tlelru_checker.sv
// ----------------------------------------------------------------------------
// tlelru_checker
// Port-level checks on result delivery and the hit/miss counters.
// ----------------------------------------------------------------------------
module tlelru_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  outcome_o,
  input logic [31:0] upper_hit_count_o,
  input logic [31:0] lower_hit_count_o,
  input logic [31:0] miss_count_o
);

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(outcome_o))
    else $error("stalled result changed");

  a_counts_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(upper_hit_count_o) &&
      $stable(lower_hit_count_o) && $stable(miss_count_o))
    else $error("counter moved under a stalled result");

  a_one_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({upper_hit_count_o != $past(upper_hit_count_o),
                lower_hit_count_o != $past(lower_hit_count_o),
                miss_count_o != $past(miss_count_o)}) <= 1)
    else $error("more than one counter moved");

  a_count_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upper_hit_count_o != $past(upper_hit_count_o)) ||
    (lower_hit_count_o != $past(lower_hit_count_o)) ||
    (miss_count_o != $past(miss_count_o)) |-> out_valid_o)
    else $error("counter moved without a new result");

  a_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upper_hit_count_o >= $past(upper_hit_count_o) &&
    lower_hit_count_o >= $past(lower_hit_count_o) &&
    miss_count_o >= $past(miss_count_o))
    else $error("counter decreased");

endmodule

bind two_level_exclusive_lru_cache tlelru_checker u_tlelru_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .outcome_o         (outcome_o),
  .upper_hit_count_o (upper_hit_count_o),
  .lower_hit_count_o (lower_hit_count_o),
  .miss_count_o      (miss_count_o)
);

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-level exclusive LRU key store. A directed
// table covers reset state, key extremes, capacity clamping and cutting; then
// randomized phases at several capacity settings hit both levels heavily.
// Each result is checked against a typed table value or a local recency-list model of both levels.
// ----------------------------------------------------------------------------
module tb;
  import tlelru_pkg::*;

  localparam int UpperDepth = 16;
  localparam int LowerDepth = 64;
  localparam int Phases     = 7;
  localparam int PhaseItems = 155;
  localparam int HoldCycles = 60;

  typedef struct packed {
    outcome_e          outcome;
    logic [CntW-1:0]   upper_hits;
    logic [CntW-1:0]   lower_hits;
    logic [CntW-1:0]   misses;
  } access_result_t;

  typedef enum logic [0:0] {
    ROW_ACCESS = 1'b0,
    ROW_WRITE  = 1'b1
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    cfg_idx_e          reg_idx;
    logic [KeyInW-1:0] value;
    logic              typed;
    access_result_t    result;
  } plan_row_t;

  localparam access_result_t NoCheck = '0;
  localparam int PlanLen = 32;

  // capacity writes clamp: zero becomes one, above depth saturates
  localparam plan_row_t Plan [PlanLen] = '{
    '{ROW_ACCESS, REG_UPPER_CAP, 32'h0000_0000, 1'b1, '{OUT_MISS, 32'd0, 32'd0, 32'd1}},
    '{ROW_ACCESS, REG_UPPER_CAP, 32'h0000_0000, 1'b1,
      '{OUT_UPPER_HIT, 32'd1, 32'd0, 32'd1}},
    '{ROW_ACCESS, REG_UPPER_CAP, 32'hFFFF_FFFF, 1'b1, '{OUT_MISS, 32'd1, 32'd0, 32'd2}},
    '{ROW_WRITE,  REG_UPPER_CAP, 32'd0,         1'b0, NoCheck},
    '{ROW_WRITE,  REG_LOWER_CAP, 32'd0,         1'b0, NoCheck},
    '{ROW_ACCESS, REG_UPPER_CAP, 32'h0000_0000, 1'b1, '{OUT_MISS, 32'd1, 32'd0, 32'd3}},
    '{ROW_ACCESS, REG_UPPER_CAP, 32'h0000_0000, 1'b1,
      '{OUT_LOWER_HIT, 32'd1, 32'd1, 32'd3}},
    '{ROW_ACCESS, REG_UPPER_CAP, 32'hFFFF_FFFF, 1'b1,
      '{OUT_LOWER_HIT, 32'd1, 32'd2, 32'd3}},
    '{ROW_ACCESS, REG_UPPER_CAP, 32'h0000_0005, 1'b0, NoCheck},
    '{ROW_ACCESS, REG_UPPER_CAP, 32'h0000_0000, 1'b0, NoCheck},
    '{ROW_WRITE,  REG_UPPER_CAP, 32'h7F,        1'b0, NoCheck},
    '{ROW_WRITE,  REG_LOWER_CAP, 32'h7F,        1'b0, NoCheck},
    '{ROW_ACCESS, REG_UPPER_CAP, 32'h8000_0000, 1'b0, NoCheck},
    '{ROW_ACCESS, REG_UPPER_CAP, 32'h5555_5555, 1'b0, NoCheck},
    '{ROW_ACCESS, REG_UPPER_CAP, 32'hAAAA_AAAA, 1'b0, NoCheck},
    '{ROW_ACCESS, REG_UPPER_CAP, 32'h7FFF_FFFF, 1'b0, NoCheck},
    '{ROW_ACCESS, REG_UPPER_CAP, 32'h0000_0005, 1'b0, NoCheck},
    '{ROW_ACCESS, REG_UPPER_CAP, 32'h0000_0000, 1'b0, NoCheck},
    '{ROW_WRITE,  REG_UPPER_CAP, 32'd3,         1'b0, NoCheck},
    '{ROW_WRITE,  REG_LOWER_CAP, 32'd2,         1'b0, NoCheck},
    '{ROW_ACCESS, REG_UPPER_CAP, 32'h0000_0001, 1'b0, NoCheck},
    '{ROW_ACCESS, REG_UPPER_CAP, 32'h0000_0002, 1'b0, NoCheck},
    '{ROW_ACCESS, REG_UPPER_CAP, 32'h0000_0003, 1'b0, NoCheck},
    '{ROW_ACCESS, REG_UPPER_CAP, 32'h0000_0004, 1'b0, NoCheck},
    '{ROW_ACCESS, REG_UPPER_CAP, 32'h0000_0005, 1'b0, NoCheck},
    '{ROW_ACCESS, REG_UPPER_CAP, 32'h0000_0001, 1'b0, NoCheck},
    '{ROW_ACCESS, REG_UPPER_CAP, 32'h0000_0002, 1'b0, NoCheck},
    '{ROW_WRITE,  REG_UPPER_CAP, 32'd1,         1'b0, NoCheck},
    '{ROW_WRITE,  REG_LOWER_CAP, 32'd65,        1'b0, NoCheck},
    '{ROW_ACCESS, REG_UPPER_CAP, 32'h0000_0003, 1'b0, NoCheck},
    '{ROW_ACCESS, REG_UPPER_CAP, 32'h0000_0004, 1'b0, NoCheck},
    '{ROW_WRITE,  REG_UPPER_CAP, 32'd16,        1'b0, NoCheck}
  };

  localparam logic [CfgDataW-1:0] PhaseUpper [Phases] = '{7'd1, 7'd16, 7'd4, 7'd1,
                                                          7'd0, 7'd0, 7'd16};
  localparam logic [CfgDataW-1:0] PhaseLower [Phases] = '{7'd1, 7'd64, 7'd1, 7'd64,
                                                          7'd0, 7'd0, 7'd64};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  cfg_idx_e              cfg_index_i;
  logic [CfgDataW-1:0]   cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [KeyInW-1:0]     access_key_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  outcome_e              outcome_o;
  logic [CntW-1:0]       upper_hit_count_o;
  logic [CntW-1:0]       lower_hit_count_o;
  logic [CntW-1:0]       miss_count_o;

  two_level_exclusive_lru_cache u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .access_key_i      (access_key_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .outcome_o         (outcome_o),
    .upper_hit_count_o (upper_hit_count_o),
    .lower_hit_count_o (lower_hit_count_o),
    .miss_count_o      (miss_count_o)
  );

  // recency lists, index 0 is MRU
  logic [KeyInW-1:0] upper_row [UpperDepth];
  logic [KeyInW-1:0] lower_row [LowerDepth];
  int                upper_fill;
  int                lower_fill;
  int                upper_cap;
  int                lower_cap;
  logic [CntW-1:0]   upper_hits;
  logic [CntW-1:0]   lower_hits;
  logic [CntW-1:0]   miss_total;

  access_result_t    pending_results [$];
  int unsigned       mismatches;
  bit                steady;
  bit                hold_req;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic void lower_insert(logic [KeyInW-1:0] key);
    if (lower_fill >= lower_cap) lower_fill = lower_cap - 1;
    for (int i = lower_fill; i > 0; i--) lower_row[i] = lower_row[i-1];
    lower_row[0] = key;
    lower_fill++;
  endfunction

  // a full upper level demotes its LRU key to the lower MRU
  function automatic void upper_insert(logic [KeyInW-1:0] key);
    if (upper_fill >= upper_cap) begin
      lower_insert(upper_row[upper_cap-1]);
      upper_fill = upper_cap - 1;
    end
    for (int i = upper_fill; i > 0; i--) upper_row[i] = upper_row[i-1];
    upper_row[0] = key;
    upper_fill++;
  endfunction

  function automatic access_result_t predict_access(logic [KeyInW-1:0] key);
    int pos;
    access_result_t res;
    pos = -1;
    for (int i = 0; i < upper_fill; i++) if (pos < 0 && upper_row[i] == key) pos = i;
    if (pos >= 0) begin
      for (int i = pos; i > 0; i--) upper_row[i] = upper_row[i-1];
      upper_row[0] = key;
      if (upper_hits != '1) upper_hits++;
      res.outcome = OUT_UPPER_HIT;
    end else begin
      for (int i = 0; i < lower_fill; i++) if (pos < 0 && lower_row[i] == key) pos = i;
      if (pos >= 0) begin
        for (int i = pos; i + 1 < lower_fill; i++) lower_row[i] = lower_row[i+1];
        lower_fill--;
        upper_insert(key);
        if (lower_hits != '1) lower_hits++;
        res.outcome = OUT_LOWER_HIT;
      end else begin
        if (upper_fill < upper_cap) upper_insert(key);
        else lower_insert(key);
        if (miss_total != '1) miss_total++;
        res.outcome = OUT_MISS;
      end
    end
    res.upper_hits = upper_hits;
    res.lower_hits = lower_hits;
    res.misses     = miss_total;
    return res;
  endfunction

  // lowering a capacity below the fill drops the LRU keys outright
  function automatic void apply_setting(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    int v;
    if (idx == REG_UPPER_CAP) begin
      v = int'(val[UpperCapW-1:0]);
      if (v == 0) v = 1;
      if (v > UpperDepth) v = UpperDepth;
      upper_cap = v;
      if (upper_fill > upper_cap) upper_fill = upper_cap;
    end else begin
      v = int'(val[LowerCapW-1:0]);
      if (v == 0) v = 1;
      if (v > LowerDepth) v = LowerDepth;
      lower_cap = v;
      if (lower_fill > lower_cap) lower_fill = lower_cap;
    end
  endfunction

  function automatic void check_field(string name, logic [CntW-1:0] want,
                                      logic [CntW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    apply_setting(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic offer(logic [KeyInW-1:0] key, logic typed, access_result_t given);
    access_result_t predicted;
    in_valid_i   <= 1'b1;
    access_key_i <= key;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = predict_access(key);
    pending_results.push_back(typed ? given : predicted);
    if (!steady && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    out_ready_i = 1'b1;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    access_result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with no request outstanding, expected none, actual %0d",
                   $time, outcome_o);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("outcome", 32'(want.outcome), 32'(outcome_o));
          check_field("upper_hit_count", want.upper_hits, upper_hit_count_o);
          check_field("lower_hit_count", want.lower_hits, lower_hit_count_o);
          check_field("miss_count", want.misses, miss_count_o);
        end
      end
    end
  end

  initial begin
    logic [KeyInW-1:0] base;
    int                span;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = REG_UPPER_CAP;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    access_key_i = '0;
    steady       = 1'b0;
    hold_req     = 1'b0;
    mismatches   = 0;
    upper_fill   = 0;
    lower_fill   = 0;
    upper_cap    = UpperCapRst;
    lower_cap    = LowerCapRst;
    upper_hits   = '0;
    lower_hits   = '0;
    miss_total   = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < PlanLen; r++) begin
      if (Plan[r].kind == ROW_WRITE) begin
        settle();
        write_reg(Plan[r].reg_idx, Plan[r].value[CfgDataW-1:0]);
      end else begin
        offer(Plan[r].value, Plan[r].typed, Plan[r].result);
      end
    end

    for (int ph = 0; ph < Phases; ph++) begin
      settle();
      if (ph == 4 || ph == 5) begin
        write_reg(REG_UPPER_CAP, CfgDataW'($urandom_range(0, 127)));
        write_reg(REG_LOWER_CAP, CfgDataW'($urandom_range(0, 127)));
      end else begin
        write_reg(REG_UPPER_CAP, PhaseUpper[ph]);
        write_reg(REG_LOWER_CAP, PhaseLower[ph]);
      end
      base = $urandom;
      for (int n = 0; n < PhaseItems; n++) begin
        steady = (ph == Phases - 1) || (n % 128 >= 100);
        if (ph == 1 && n == 40) hold_req = 1'b1;
        if (ph == 2 && n == 80) settle();
        // key pool slightly larger than both levels together
        span = upper_cap + lower_cap + $urandom_range(1, 8);
        if ($urandom_range(0, 15) == 0) offer($urandom, 1'b0, NoCheck);
        else offer(base + KeyInW'($urandom_range(0, span - 1)), 1'b0, NoCheck);
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/tlelru_pkg.sv
rtl/two_level_exclusive_lru_cache.sv
rtl/tlelru_checker.sv
bench/tb.sv
